>>> sv/fpdf_pkg.sv
package fpdf_pkg;

	localparam int VALUE_W     = 48;
	localparam int CHAR_W      = 7;
	localparam int POS_W       = 6;   // holds any field width up to the largest MAX_WIDTH (32)
	localparam int FW_REG_W    = 5;
	localparam int FRAC_W      = 4;
	localparam int DEC_LIMIT   = 8;
	localparam int FRAC_AW     = $clog2(DEC_LIMIT);
	localparam int FDEC_W      = 27;  // 10^8 - 1 fits
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;

	localparam int MAX_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 2'd1;

	localparam logic [FW_REG_W-1:0] FIELD_WIDTH_RST = 5'd8;
	localparam logic [FRAC_W-1:0]   FRAC_DIGITS_RST = 4'd0;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

	// per-item field layout, resolved from the config registers at entry
	typedef struct packed {
		logic [POS_W-1:0]  width;
		logic [FRAC_W-1:0] frac;
		logic [POS_W-1:0]  int_len;
	} fmt_info_t;

	function automatic logic [FDEC_W-1:0] pow10(input logic [FRAC_W-1:0] k);
		logic [FDEC_W-1:0] r;
		case (k)
			4'd0: r = 27'd1;
			4'd1: r = 27'd10;
			4'd2: r = 27'd100;
			4'd3: r = 27'd1000;
			4'd4: r = 27'd10000;
			4'd5: r = 27'd100000;
			4'd6: r = 27'd1000000;
			4'd7: r = 27'd10000000;
			4'd8: r = 27'd100000000;
			default: r = 27'd1;
		endcase
		return r;
	endfunction

endpackage

>>> sv/fpdf_conv.sv
// Pipelined shift-and-add-3 conversion, integer and fraction lanes side by side.
module fpdf_conv
	import fpdf_pkg::*;
#(
	parameter int IW     = 32,
	parameter int ND     = 16,
	parameter int STAGES = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    in_valid,
	input  fmt_info_t               in_info,
	input  logic [IW-1:0]           ibin,
	input  logic [FDEC_W-1:0]       fbin,
	output logic                    out_valid,
	output fmt_info_t               out_info,
	output logic [ND*4-1:0]         idig,
	output logic [DEC_LIMIT*4-1:0]  fdig
);

	localparam int IBPS = (IW + STAGES - 1) / STAGES;
	localparam int IPW  = IBPS * STAGES;
	localparam int FBPS = (FDEC_W + STAGES - 1) / STAGES;
	localparam int FPW  = FBPS * STAGES;
	localparam int FD   = DEC_LIMIT;

	logic                 vld_s  [STAGES];
	fmt_info_t            info_s [STAGES];
	logic [IPW-1:0]       ibin_s [STAGES];
	logic [ND*4-1:0]      ibcd_s [STAGES];
	logic [FPW-1:0]       fbin_s [STAGES];
	logic [FD*4-1:0]      fbcd_s [STAGES];

	for (genvar st = 0; st < STAGES; st++) begin : g_stage
		logic            vld_in;
		fmt_info_t       info_in;
		logic [IPW-1:0]  ib_in, ib_nx;
		logic [ND*4-1:0] id_in, id_nx;
		logic [FPW-1:0]  fb_in, fb_nx;
		logic [FD*4-1:0] fd_in, fd_nx;

		if (st == 0) begin : g_first
			assign vld_in  = in_valid;
			assign info_in = in_info;
			assign ib_in   = IPW'(ibin);
			assign id_in   = '0;
			assign fb_in   = FPW'(fbin);
			assign fd_in   = '0;
		end else begin : g_next
			assign vld_in  = vld_s[st-1];
			assign info_in = info_s[st-1];
			assign ib_in   = ibin_s[st-1];
			assign id_in   = ibcd_s[st-1];
			assign fb_in   = fbin_s[st-1];
			assign fd_in   = fbcd_s[st-1];
		end

		always_comb begin
			logic [IPW-1:0]  b;
			logic [ND*4-1:0] d;
			b = ib_in;
			d = id_in;
			for (int n = 0; n < IBPS; n++) begin
				for (int m = 0; m < ND; m++) begin
					if (d[m*4 +: 4] >= 4'd5)
						d[m*4 +: 4] = d[m*4 +: 4] + 4'd3;
				end
				d = {d[ND*4-2:0], b[IPW-1]};
				b = b << 1;
			end
			ib_nx = b;
			id_nx = d;
		end

		always_comb begin
			logic [FPW-1:0]  b;
			logic [FD*4-1:0] d;
			b = fb_in;
			d = fd_in;
			for (int n = 0; n < FBPS; n++) begin
				for (int m = 0; m < FD; m++) begin
					if (d[m*4 +: 4] >= 4'd5)
						d[m*4 +: 4] = d[m*4 +: 4] + 4'd3;
				end
				d = {d[FD*4-2:0], b[FPW-1]};
				b = b << 1;
			end
			fb_nx = b;
			fd_nx = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[st] <= 1'b0;
			else if (advance)
				vld_s[st] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				info_s[st] <= info_in;
				ibin_s[st] <= ib_nx;
				ibcd_s[st] <= id_nx;
				fbin_s[st] <= fb_nx;
				fbcd_s[st] <= fd_nx;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_info  = info_s[STAGES-1];
	assign idig      = ibcd_s[STAGES-1];
	assign fdig      = fbcd_s[STAGES-1];

endmodule

>>> sv/fpdf_emit.sv
// Character build (blanking, forced zero) and the per-character serializer.
module fpdf_emit
	import fpdf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  fmt_info_t                    in_info,
	input  logic [MAX_WIDTH*4-1:0]       idig,
	input  logic [DEC_LIMIT*4-1:0]       fdig,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CHAR_W-1:0]            text_char,
	output logic                         last
);

	localparam int ND    = MAX_WIDTH;
	localparam int IDX_W = $clog2(MAX_WIDTH);

	logic [ND-1:0]     nzm, nz;
	logic [CHAR_W-1:0] int_chr_n  [ND];
	logic [CHAR_W-1:0] frac_chr_n [DEC_LIMIT];

	logic              v_s1;
	fmt_info_t         info_s1;
	logic [CHAR_W-1:0] int_chr_s1  [ND];
	logic [CHAR_W-1:0] frac_chr_s1 [DEC_LIMIT];

	logic              buf_v_q;
	fmt_info_t         info_q;
	logic [CHAR_W-1:0] int_chr_q  [ND];
	logic [CHAR_W-1:0] frac_chr_q [DEC_LIMIT];
	logic [IDX_W-1:0]  emit_index_q;

	logic              out_v_q;
	logic [CHAR_W-1:0] text_char_q;
	logic              last_q;

	logic              fire, is_last, buf_take, adv;
	logic [POS_W-1:0]  pos, ioff, foff;
	logic [CHAR_W-1:0] chr;

	// nz[j]: some integer digit at or above j is nonzero
	always_comb begin
		for (int j = 0; j < ND; j++)
			nzm[j] = (idig[j*4 +: 4] != 4'd0) && (POS_W'(j) < in_info.int_len);
		for (int j = 0; j < ND; j++)
			nz[j] = |(nzm >> j);
		for (int j = 0; j < ND; j++) begin
			if (j == 0 && !nz[j])
				int_chr_n[j] = CH_ZERO;
			else if (!nz[j])
				int_chr_n[j] = CH_SPACE;
			else
				int_chr_n[j] = CH_ZERO + CHAR_W'(idig[j*4 +: 4]);
		end
		for (int j = 0; j < DEC_LIMIT; j++)
			frac_chr_n[j] = CH_ZERO + CHAR_W'(fdig[j*4 +: 4]);
	end

	assign pos     = POS_W'(emit_index_q);
	assign ioff    = info_q.int_len - POS_W'(1) - pos;
	assign foff    = info_q.width - POS_W'(1) - pos;
	assign is_last = (pos == info_q.width - POS_W'(1));
	assign fire    = buf_v_q && (!out_v_q || out_ready);
	assign buf_take = !buf_v_q || (fire && is_last);
	assign adv     = !v_s1 || buf_take;
	assign in_ready = adv;

	always_comb begin
		if (pos < info_q.int_len)
			chr = int_chr_q[ioff[IDX_W-1:0]];
		else if (pos == info_q.int_len)
			chr = CH_POINT;
		else
			chr = frac_chr_q[foff[FRAC_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			buf_v_q      <= 1'b0;
			emit_index_q <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (adv)
				v_s1 <= in_valid;
			if (buf_take)
				buf_v_q <= v_s1;
			if (fire)
				emit_index_q <= is_last ? '0 : emit_index_q + IDX_W'(1);
			if (fire)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s1     <= in_info;
			int_chr_s1  <= int_chr_n;
			frac_chr_s1 <= frac_chr_n;
		end
		if (buf_take) begin
			info_q     <= info_s1;
			int_chr_q  <= int_chr_s1;
			frac_chr_q <= frac_chr_s1;
		end
		if (fire) begin
			text_char_q <= chr;
			last_q      <= is_last;
		end
	end

	assign out_valid = out_v_q;
	assign text_char = text_char_q;
	assign last      = last_q;

	a_idx_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		buf_v_q |-> pos < info_q.width)
		else $error("emit index beyond field width");

	a_idx_rest: assert property (@(posedge clk) disable iff (!arst_n)
		!buf_v_q |-> emit_index_q == '0)
		else $error("emit index not at zero with empty buffer");

	a_layout: assert property (@(posedge clk) disable iff (!arst_n)
		buf_v_q |-> ((info_q.frac == '0) ? (info_q.int_len == info_q.width)
			: (info_q.int_len + POS_W'(info_q.frac) + POS_W'(1) == info_q.width)))
		else $error("field layout inconsistent");

endmodule

>>> sv/fixed_point_decimal_formatter.sv
// Fixed-point decimal formatter. Each value on the input (FRAC_BITS fraction bits)
// becomes a right-aligned ASCII field of field_width characters, one character per
// output transfer, last high on the final one. Leading integer zeros print as spaces,
// integer digits that do not fit are dropped, fraction digits are truncated. With
// frac_digits = 0 no point is printed and a zero value shows a single '0'. An item
// occupies the output for field_width characters (1..MAX_WIDTH after saturation), and
// the one-character-per-cycle output register sets the sustained rate while out_ready
// stays high; the next item is taken while the current one is still being sent. The
// first character passes through the input and multiply stages, the conversion
// pipeline, a formatting stage, the field buffer and the output register. Config
// writes (cfg_index 0: field_width, 1: frac_digits, others ignored) are accepted every
// cycle and must only happen while the block is idle.
module fixed_point_decimal_formatter
	import fpdf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_W-1:0]    value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     text_char,
	output logic                  last
);

	localparam int IW     = VALUE_W - FRAC_BITS;
	localparam int STAGES = (IW + 3) / 4;
	localparam int PROD_W = FRAC_BITS + FDEC_W;

	logic [FW_REG_W-1:0] field_width_q;
	logic [FRAC_W-1:0]   frac_digits_q;

	fmt_info_t           info_in;
	logic                pipe_adv;

	logic                v_s1;
	fmt_info_t           info_s1;
	logic [VALUE_W-1:0]  value_s1;

	logic                v_s2;
	fmt_info_t           info_s2;
	logic [IW-1:0]       ipart_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic                cv_valid;
	fmt_info_t           cv_info;
	logic [MAX_WIDTH*4-1:0] cv_idig;
	logic [DEC_LIMIT*4-1:0] cv_fdig;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= FIELD_WIDTH_RST;
			frac_digits_q <= FRAC_DIGITS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIELD_WIDTH: field_width_q <= cfg_data[FW_REG_W-1:0];
				REG_FRAC_DIGITS: frac_digits_q <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate width and decimals; the point must always fit
	always_comb begin
		logic [POS_W-1:0]  w;
		logic [FRAC_W-1:0] k;
		if (field_width_q == '0)
			w = POS_W'(1);
		else if (POS_W'(field_width_q) > POS_W'(MAX_WIDTH))
			w = POS_W'(MAX_WIDTH);
		else
			w = POS_W'(field_width_q);
		k = (frac_digits_q > FRAC_W'(DEC_LIMIT)) ? FRAC_W'(DEC_LIMIT) : frac_digits_q;
		if (POS_W'(k) > w - POS_W'(1))
			k = FRAC_W'(w - POS_W'(1));
		info_in.width   = w;
		info_in.frac    = k;
		info_in.int_len = (k == '0) ? w : (w - POS_W'(k) - POS_W'(1));
	end

	assign in_ready = pipe_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (pipe_adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_adv) begin
			info_s1  <= info_in;
			value_s1 <= value;
			info_s2  <= info_s1;
			ipart_s2 <= value_s1[VALUE_W-1:FRAC_BITS];
			prod_s2  <= value_s1[FRAC_BITS-1:0] * pow10(info_s1.frac);
		end
	end

	fpdf_conv #(
		.IW     (IW),
		.ND     (MAX_WIDTH),
		.STAGES (STAGES)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (pipe_adv),
		.in_valid  (v_s2),
		.in_info   (info_s2),
		.ibin      (ipart_s2),
		.fbin      (prod_s2[PROD_W-1:FRAC_BITS]),
		.out_valid (cv_valid),
		.out_info  (cv_info),
		.idig      (cv_idig),
		.fdig      (cv_fdig)
	);

	fpdf_emit #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv_valid),
		.in_ready  (pipe_adv),
		.in_info   (cv_info),
		.idig      (cv_idig),
		.fdig      (cv_fdig),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_char (text_char),
		.last      (last)
	);

	a_info_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (info_s1.width != '0) && (info_s1.width <= POS_W'(MAX_WIDTH))
			&& (info_s1.frac <= FRAC_W'(DEC_LIMIT)))
		else $error("resolved field layout out of range");

	a_frac_product: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> prod_s2[PROD_W-1:FRAC_BITS] < pow10(info_s2.frac))
		else $error("fraction digits exceed decimal count");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import fpdf_pkg::*;

	localparam int MAX_W        = MAX_WIDTH_DEF;
	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_LEN     = 300;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              lst;
	} field_char_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [VALUE_W-1:0]    value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CHAR_W-1:0]     text_char;
	logic                  last;

	fixed_point_decimal_formatter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_char (text_char),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the format registers, reset values
	logic [FW_REG_W-1:0] fw_reg = FIELD_WIDTH_RST;
	logic [FRAC_W-1:0]   fd_reg = FRAC_DIGITS_RST;

	logic [VALUE_W-1:0] value_queue[$];
	field_char_t        expected_text[$];

	int tx_idle_max = 0;
	int rx_idle_max = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_cnt = 0;
	logic rx_hold = 1'b0;

	int failures = 0;
	int values_sent = 0;
	int chars_checked = 0;
	int settings_run = 1;
	int stall_cnt = 0;

	// expected characters of one formatted field
	function automatic void render_field(input logic [VALUE_W-1:0] v);
		int unsigned w, k, int_len, i;
		logic [63:0] ipart, fdec, scale;
		logic [3:0] dig[MAX_W];
		logic [CHAR_W-1:0] txt[MAX_W];
		bit lead;
		field_char_t c;
		w = fw_reg;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		k = fd_reg;
		if (k > DEC_LIMIT) k = DEC_LIMIT;
		if (k > w - 1) k = w - 1;
		scale = 64'd1;
		for (i = 0; i < k; i++) scale = scale * 64'd10;
		ipart = 64'(v) >> FRAC_BITS;
		fdec = ((64'(v) & ((64'd1 << FRAC_BITS) - 1)) * scale) >> FRAC_BITS;
		int_len = (k == 0) ? w : (w - k - 1);
		for (i = 0; i < int_len; i++) begin
			dig[int_len - 1 - i] = 4'(ipart % 10);
			ipart = ipart / 10;
		end
		for (i = 0; i < k; i++) begin
			dig[w - 1 - i] = 4'(fdec % 10);
			fdec = fdec / 10;
		end
		lead = 1'b1;
		for (i = 0; i < int_len; i++) begin
			if (dig[i] == 4'd0 && lead) begin
				txt[i] = CH_SPACE;
			end else begin
				lead = 1'b0;
				txt[i] = CH_ZERO + CHAR_W'(dig[i]);
			end
		end
		if (k == 0) begin
			if (lead) txt[w - 1] = CH_ZERO;
		end else begin
			// blank integer part still gets a zero before the point, if there is room
			if (lead && int_len > 0) txt[int_len - 1] = CH_ZERO;
			txt[int_len] = CH_POINT;
			for (i = int_len + 1; i < w; i++) txt[i] = CH_ZERO + CHAR_W'(dig[i]);
		end
		for (i = 0; i < w; i++) begin
			c.ch = txt[i];
			c.lst = (i == w - 1);
			expected_text.push_back(c);
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			tx_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				render_field(value);
				values_sent++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (value_queue.size() != 0) begin
					value <= value_queue.pop_front();
					in_valid <= 1'b1;
					tx_wait = $urandom_range(0, tx_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_done < hold_req) begin
			if (hold_cnt == HOLD_LEN - 1) begin
				hold_cnt <= 0;
				hold_done <= hold_done + 1;
				rx_hold <= 1'b0;
			end else begin
				hold_cnt <= hold_cnt + 1;
				rx_hold <= 1'b1;
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		field_char_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				chars_checked++;
				if (expected_text.size() == 0) begin
					$error("unexpected character %h (last %b)", text_char, last);
					failures++;
				end else begin
					e = expected_text.pop_front();
					if (text_char !== e.ch) begin
						$error("text_char: expected %h, got %h", e.ch, text_char);
						failures++;
					end
					if (last !== e.lst) begin
						$error("last: expected %b, got %b", e.lst, last);
						failures++;
					end
				end
				rx_wait = $urandom_range(0, rx_idle_max);
			end else if (rx_wait > 0 && !rx_hold) begin
				rx_wait--;
			end
			out_ready <= !rx_hold && rx_wait == 0;
		end
	end

	// watchdog: cycles with work pending but no transfer anywhere
	always @(posedge clk) begin
		if (arst_n && (value_queue.size() != 0 || in_valid || expected_text.size() != 0)
			&& !(in_valid && in_ready) && !(out_valid && out_ready)
			&& !(cfg_valid && cfg_ready)) begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles, %0d characters outstanding",
					stall_cnt, expected_text.size());
				$display("Verification failed");
				$finish;
			end
		end else begin
			stall_cnt <= 0;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FIELD_WIDTH) fw_reg = data[FW_REG_W-1:0];
		else if (idx == REG_FRAC_DIGITS) fd_reg = data[FRAC_W-1:0];
	endtask

	task automatic set_format(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fd);
		write_reg(REG_FIELD_WIDTH, fw);
		write_reg(REG_FRAC_DIGITS, fd);
		settings_run++;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (value_queue.size() != 0 || in_valid || expected_text.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input bit pressure);
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
			1: begin tx_idle_max = 17; rx_idle_max = 17; end
			2: begin tx_idle_max = 17; rx_idle_max = 0;  end
			default: begin tx_idle_max = 0; rx_idle_max = 17; end
		endcase
		if (pressure) begin
			tx_idle_max = 0;
			rx_idle_max = 0;
			hold_req++;
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: v = VALUE_W'({$urandom, $urandom});
				1: v = {32'($urandom_range(0, 999)), 16'($urandom)};
				2: v = {32'd0, 16'($urandom)};
				3: v = {32'($urandom), 16'd0};
				4: v = {32'($urandom_range(0, 99999)), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
				default: v = $urandom_range(0, 1) ? '1 : VALUE_W'($urandom_range(0, 3));
			endcase
			value_queue.push_back(v);
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// reset format: 8 wide integer mode
		tx_idle_max = 17;
		rx_idle_max = 17;
		value_queue.push_back('0);
		value_queue.push_back(48'h0000_0001_0000);
		value_queue.push_back('1);
		value_queue.push_back(VALUE_W'(12345) << FRAC_BITS);
		value_queue.push_back(48'h0000_0000_8000);
		wait_idle();

		// width zero acts as one, which forces integer mode
		set_format(5'd0, 5'd3);
		value_queue.push_back(VALUE_W'(7) << FRAC_BITS);
		value_queue.push_back('0);
		wait_idle();

		// width and decimals both saturate
		set_format(5'd31, 5'd15);
		value_queue.push_back('1);
		value_queue.push_back('0);
		value_queue.push_back(48'h0000_0000_0001);
		value_queue.push_back(48'h0000_0000_FFFF);
		wait_idle();

		// point comes first, no integer position
		set_format(5'd4, 5'd3);
		value_queue.push_back(48'h0000_0000_8000);
		value_queue.push_back(48'h0000_0000_FFFF);
		value_queue.push_back(VALUE_W'(5) << FRAC_BITS);
		wait_idle();

		// blank integer part gets a zero before the point
		set_format(5'd5, 5'd3);
		value_queue.push_back('0);
		value_queue.push_back(48'h0000_0000_1999);
		wait_idle();

		// writes to unused indexes change nothing
		write_reg(2'd2, 5'h1F);
		write_reg(2'd3, 5'h0A);
		value_queue.push_back(48'h0000_002A_4000);
		value_queue.push_back('1);
		wait_idle();

		// integer digits beyond the field wrap away
		set_format(5'd3, 5'd0);
		value_queue.push_back(VALUE_W'(12345) << FRAC_BITS);
		value_queue.push_back(VALUE_W'(1000) << FRAC_BITS);
		value_queue.push_back('0);
		wait_idle();

		set_format(5'd16, 5'd0);
		value_queue.push_back('1);
		value_queue.push_back('0);
		wait_idle();

		// random part: extremes first, then random settings
		set_format(5'd1, 5'd0);
		random_phase(50, 1'b0);
		set_format(5'd1, 5'd8);
		random_phase(50, 1'b0);
		set_format(5'd16, 5'd8);
		random_phase(50, 1'b1);
		set_format(5'd16, 5'd0);
		random_phase(50, 1'b0);
		for (int p = 0; p < 6; p++) begin
			if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 3)),
				CFG_DATA_W'($urandom));
			if ($urandom_range(0, 1))
				set_format(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(0, 31)));
			else
				set_format(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)));
			random_phase(50, p == 3);
		end

		$display("%0d values formatted into %0d checked characters over %0d format settings",
			values_sent, chars_checked, settings_run);
		$display("%0d receiver hold-offs of %0d cycles, %0d mismatches",
			hold_done, HOLD_LEN, failures);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
